[hw/rtl/thsp_pkg.sv]
`timescale 1ns / 1ps
package thsp_pkg;

   localparam int MaxTagsDefault        = 128;
   localparam int NameFieldBytesDefault = 64;
   localparam int VrFieldBytesDefault   = 4;
   localparam int QueueDepth            = 8;
   localparam int ResultsPerItem        = 3;

   localparam logic [31:0] MAGIC_WORD = 32'h3031_5653;
   localparam logic [31:0] SYNC_A     = 32'd77;
   localparam logic [31:0] SYNC_B     = 32'd205;

   typedef enum logic [3:0] {
      PH_MAGIC, PH_SPARE, PH_COUNT, PH_HSYNC, PH_NAME, PH_NAMEPAD, PH_VM, PH_VR,
      PH_VRPAD, PH_TYPE, PH_NITEMS, PH_ISYNC, PH_ITEMHDR, PH_DATA, PH_ITEMPAD, PH_IDLE
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NAME, KIND_VR, KIND_VALUE, KIND_EMPTY, KIND_TAG_END, KIND_DONE, KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_MAGIC, ERR_TAG_COUNT, ERR_HEADER_SYNC, ERR_NAME_LONG,
      ERR_VR_LONG, ERR_ITEM_SYNC, ERR_DUPLICATE, ERR_TRUNCATED
   } err_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] tag;
      logic [7:0] payload;
      logic       vlast;
      logic [2:0] err;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic [6:0] pos;
      logic [7:0] tag;
      logic       term;
   } name_req_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic [7:0] load_count;
   } name_ctl_type;

endpackage

[hw/rtl/thsp_ram.sv]
`timescale 1ns / 1ps
module thsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/thsp_name_check.sv]
`timescale 1ns / 1ps
module thsp_name_check #(
   parameter int MAX_TAGS         = 128,
   parameter int NAME_FIELD_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  thsp_pkg::name_req_type name_req,
   input  thsp_pkg::name_ctl_type name_ctl,
   output logic                  dup_seen
);
   import thsp_pkg::*;

   localparam int RW   = MAX_TAGS * 8;
   localparam int AW   = $clog2(NAME_FIELD_BYTES);
   localparam int TAGW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

   name_req_type        s2_ff;
   logic [MAX_TAGS-1:0] mask_ff, mask_in;
   logic                dup_ff, dup_in;
   logic [RW-1:0]       row;
   logic [RW-1:0]       wrow;
   logic [MAX_TAGS-1:0] eq;
   logic [TAGW-1:0]     s2_tag;

   // row per name position, one byte lane per tag
   thsp_ram #(.WIDTH(RW), .DEPTH(NAME_FIELD_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (s2_ff.valid),
      .wr_addr (s2_ff.pos[AW-1:0]),
      .wr_data (wrow),
      .rd_addr (name_req.pos[AW-1:0]),
      .rd_data (row)
   );

   assign s2_tag = s2_ff.tag[TAGW-1:0];

   always_comb begin
      wrow = row;
      for (int j = 0; j < MAX_TAGS; j++) begin
         eq[j] = (row[j*8 +: 8] == s2_ff.data);
         if (TAGW'(j) == s2_tag) begin
            wrow[j*8 +: 8] = s2_ff.data;
         end
      end
   end

   always_comb begin
      mask_in = mask_ff;
      dup_in  = dup_ff;
      if (name_ctl.clear) begin
         mask_in = '0;
         dup_in  = 1'b0;
      end else if (name_ctl.load) begin
         for (int j = 0; j < MAX_TAGS; j++) begin
            mask_in[j] = (8'(j) < name_ctl.load_count);
         end
         dup_in = 1'b0;
      end else if (s2_ff.valid) begin
         mask_in = mask_ff & eq;
         if (s2_ff.term) begin
            dup_in = dup_ff | (|(mask_ff & eq));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         mask_ff     <= '0;
         dup_ff      <= 1'b0;
      end else begin
         s2_ff.valid <= name_req.valid;
         mask_ff     <= mask_in;
         dup_ff      <= dup_in;
      end
      s2_ff.data <= name_req.data;
      s2_ff.pos  <= name_req.pos;
      s2_ff.tag  <= name_req.tag;
      s2_ff.term <= name_req.term;
   end

   assign dup_seen = dup_ff;

   assert property (@(posedge clock) disable iff (reset)
      name_ctl.clear |=> (mask_ff == '0 && !dup_ff)) else $error("mask not cleared");
   assert property (@(posedge clock) disable iff (reset)
      (s2_ff.valid && !name_ctl.clear && !name_ctl.load) |=> ((mask_ff & ~$past(mask_ff)) == '0))
      else $error("mask bit set by compare");
   assert property (@(posedge clock) disable iff (reset)
      (name_ctl.load && !name_ctl.clear) |=> !dup_ff) else $error("dup not cleared on load");
endmodule

[hw/rtl/thsp_result_queue.sv]
`timescale 1ns / 1ps
module thsp_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_n,
   input  thsp_pkg::result_type push_data [thsp_pkg::ResultsPerItem],
   output logic                room,
   output logic                out_valid,
   output thsp_pkg::result_type out_data,
   input  logic                out_ready
);
   import thsp_pkg::*;

   localparam int PW = $clog2(QueueDepth);
   localparam int CW = $clog2(QueueDepth + 1);

   result_type     q_ff [QueueDepth];
   logic [PW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = q_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= CW'(QueueDepth - ResultsPerItem));

   always_comb begin
      head_in  = pop ? head_ff + PW'(1) : head_ff;
      tail_in  = tail_ff + PW'(push_n);
      count_in = count_ff + CW'(push_n) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      for (int i = 0; i < ResultsPerItem; i++) begin
         if (2'(i) < push_n) begin
            q_ff[tail_ff + PW'(i)] <= push_data[i];
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QueueDepth)) else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> room) else $error("push without room");
   assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> push_data[push_n - 2'd1].last) else $error("run end not marked");
   assert property (@(posedge clock) disable iff (reset)
      (pop && push_n == 2'd0) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("count not decremented");
endmodule

[hw/rtl/tagged_header_stream_parser.sv]
`timescale 1ns / 1ps
// tagged header stream parser
// req channel: one header byte per item in req_tdata, req_tlast on the final
// byte of a buffer. rsp channel: parsed results (name, vr and value bytes,
// empty value, tag end, done, error), rsp_tlast on the final result of one
// input byte.
// throughput: one input byte per cycle while req_tready is high; the byte
// counters, the word assembler and the name compare each take one byte a
// cycle. a byte yields zero to three results, which are written into an
// 8-entry result queue when the byte is accepted; rsp shows the queue head.
// duplicate names are checked against a name ram (one row per name
// position, one byte lane per tag), read when the byte is accepted and
// compared and written back in the next cycle.
// reset (synchronous) empties the queue and returns to the magic field;
// the name ram is not cleared, only names of the current buffer are compared.
// when rsp stalls the queue holds results; req_tready drops while fewer than
// three queue entries are free.
module tagged_header_stream_parser #(
   parameter int MAX_TAGS         = thsp_pkg::MaxTagsDefault,
   parameter int NAME_FIELD_BYTES = thsp_pkg::NameFieldBytesDefault,
   parameter int VR_FIELD_BYTES   = thsp_pkg::VrFieldBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tag_number[6:0], payload_byte, value_last, error_code, 0
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // run_last
);
   import thsp_pkg::*;

   localparam int TAGW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int CW   = $clog2(MAX_TAGS + 1);
   localparam int FMAX = (NAME_FIELD_BYTES > 16) ? NAME_FIELD_BYTES : 16;
   localparam int FW   = $clog2(FMAX + 1);

   phase_type       phase_ff, phase_in;
   logic [FW-1:0]   fc_ff, fc_in;
   logic [31:0]     ws_ff, ws_in;
   logic [CW-1:0]   texp_ff, texp_in;
   logic [TAGW-1:0] tag_ff, tag_in;
   logic [31:0]     mult_ff, mult_in;
   logic [31:0]     items_ff, items_in;
   logic [31:0]     iidx_ff, iidx_in;
   logic [31:0]     left_ff, left_in;
   logic [1:0]      pos_ff, pos_in;

   logic            accept;
   logic            room;
   logic            dup_seen;
   name_req_type    name_req;
   name_ctl_type    name_ctl;
   result_type      res [ResultsPerItem];
   logic [1:0]      n_res;
   logic [1:0]      push_n;
   result_type      head;

   function automatic result_type mk(logic [2:0] k, logic [6:0] t, logic [7:0] p,
                                     logic v, logic [2:0] e);
      result_type r;
      r.kind    = k;
      r.tag     = t;
      r.payload = p;
      r.vlast   = v;
      r.err     = e;
      r.last    = 1'b0;
      return r;
   endfunction

   assign accept = req_tvalid && req_tready;
   assign req_tready = room;

   always_comb begin
      logic [7:0]  b;
      logic [31:0] w;
      logic        kept;
      logic        endd;
      logic        nxt;
      logic        fin;
      b        = req_tdata;
      w        = '0;
      kept     = (mult_ff == '0) || (iidx_ff < mult_ff);
      endd     = 1'b0;
      nxt      = 1'b0;
      fin      = 1'b0;
      phase_in = phase_ff;
      fc_in    = fc_ff;
      ws_in    = ws_ff;
      texp_in  = texp_ff;
      tag_in   = tag_ff;
      mult_in  = mult_ff;
      items_in = items_ff;
      iidx_in  = iidx_ff;
      left_in  = left_ff;
      pos_in   = pos_ff + 2'd1;
      n_res    = 2'd0;
      for (int i = 0; i < ResultsPerItem; i++) begin
         res[i] = '0;
      end
      name_req = '0;
      name_ctl = '0;
      if (accept) begin
         case (phase_ff)
            PH_MAGIC, PH_SPARE, PH_COUNT, PH_HSYNC, PH_VM, PH_TYPE, PH_NITEMS,
            PH_ISYNC: begin
               ws_in = ws_ff | (32'(b) << {fc_ff[1:0], 3'b000});
               fc_in = fc_ff + FW'(1);
               if (fc_in >= FW'(4)) begin
                  w     = ws_in;
                  ws_in = '0;
                  fc_in = '0;
                  case (phase_ff)
                     PH_MAGIC: begin
                        if (w != MAGIC_WORD) begin
                           res[n_res] = mk(KIND_ERROR, 7'(tag_in), 8'd0, 1'b0, ERR_MAGIC);
                           n_res = n_res + 2'd1;
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_SPARE;
                        end
                     end
                     PH_SPARE: phase_in = PH_COUNT;
                     PH_COUNT: begin
                        if (w == '0 || w > 32'(MAX_TAGS)) begin
                           res[n_res] = mk(KIND_ERROR, 7'(tag_in), 8'd0, 1'b0, ERR_TAG_COUNT);
                           n_res = n_res + 2'd1;
                           phase_in = PH_IDLE;
                        end else begin
                           texp_in  = CW'(w);
                           phase_in = PH_HSYNC;
                        end
                     end
                     PH_HSYNC: begin
                        if (w != SYNC_A) begin
                           res[n_res] = mk(KIND_ERROR, 7'(tag_in), 8'd0, 1'b0,
                                           ERR_HEADER_SYNC);
                           n_res = n_res + 2'd1;
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_NAME;
                           fc_in    = '0;
                           name_ctl.load       = 1'b1;
                           name_ctl.load_count = 8'(tag_ff);
                        end
                     end
                     PH_VM: begin
                        mult_in  = w;
                        phase_in = PH_VR;
                     end
                     PH_TYPE: phase_in = PH_NITEMS;
                     PH_NITEMS: begin
                        items_in = w;
                        phase_in = PH_ISYNC;
                     end
                     default: begin
                        if (w != SYNC_A && w != SYNC_B) begin
                           res[n_res] = mk(KIND_ERROR, 7'(tag_in), 8'd0, 1'b0, ERR_ITEM_SYNC);
                           n_res = n_res + 2'd1;
                           phase_in = PH_IDLE;
                        end else begin
                           iidx_in = '0;
                           if (items_ff == '0) begin
                              fin = 1'b1;
                           end else begin
                              phase_in = PH_ITEMHDR;
                           end
                        end
                     end
                  endcase
               end
            end
            PH_NAME: begin
               res[n_res] = mk(KIND_NAME, 7'(tag_ff), b, 1'b0, 3'd0);
               n_res = n_res + 2'd1;
               name_req.valid = !req_tlast;
               name_req.data  = b;
               name_req.pos   = 7'(fc_ff);
               name_req.tag   = 8'(tag_ff);
               name_req.term  = (b == 8'd0);
               fc_in = fc_ff + FW'(1);
               if (b == 8'd0) begin
                  phase_in = PH_NAMEPAD;
               end else if (fc_in >= FW'(NAME_FIELD_BYTES - 1)) begin
                  res[n_res] = mk(KIND_ERROR, 7'(tag_ff), 8'd0, 1'b0, ERR_NAME_LONG);
                  n_res = n_res + 2'd1;
                  phase_in = PH_IDLE;
               end
            end
            PH_NAMEPAD: begin
               fc_in = fc_ff + FW'(1);
               if (fc_in >= FW'(NAME_FIELD_BYTES)) begin
                  phase_in = PH_VM;
                  fc_in    = '0;
                  ws_in    = '0;
               end
            end
            PH_VR: begin
               res[n_res] = mk(KIND_VR, 7'(tag_ff), b, 1'b0, 3'd0);
               n_res = n_res + 2'd1;
               fc_in = fc_ff + FW'(1);
               if (b == 8'd0) begin
                  phase_in = PH_VRPAD;
               end else if (fc_in >= FW'(VR_FIELD_BYTES - 1)) begin
                  res[n_res] = mk(KIND_ERROR, 7'(tag_ff), 8'd0, 1'b0, ERR_VR_LONG);
                  n_res = n_res + 2'd1;
                  phase_in = PH_IDLE;
               end
            end
            PH_VRPAD: begin
               fc_in = fc_ff + FW'(1);
               if (fc_in >= FW'(VR_FIELD_BYTES)) begin
                  phase_in = PH_TYPE;
                  fc_in    = '0;
                  ws_in    = '0;
               end
            end
            PH_ITEMHDR: begin
               if (fc_ff >= FW'(4) && fc_ff < FW'(8)) begin
                  ws_in = ws_ff | (32'(b) << {fc_ff[1:0], 3'b000});
               end
               fc_in = fc_ff + FW'(1);
               if (fc_in >= FW'(16)) begin
                  left_in = ws_in;
                  ws_in   = '0;
                  fc_in   = '0;
                  if (left_in == '0) begin
                     if (kept) begin
                        res[n_res] = mk(KIND_EMPTY, 7'(tag_ff), 8'd0, 1'b0, 3'd0);
                        n_res = n_res + 2'd1;
                     end
                     endd = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               if (kept) begin
                  res[n_res] = mk(KIND_VALUE, 7'(tag_ff), b, (left_ff == 32'd1), 3'd0);
                  n_res = n_res + 2'd1;
               end
               left_in = left_ff - 32'd1;
               if (left_in == '0) begin
                  endd = 1'b1;
               end
            end
            PH_ITEMPAD: begin
               if (pos_in == 2'd0) begin
                  nxt = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (endd) begin
            if (pos_in != 2'd0) begin
               phase_in = PH_ITEMPAD;
            end else begin
               nxt = 1'b1;
            end
         end
         if (nxt) begin
            iidx_in = iidx_ff + 32'd1;
            if (iidx_in >= items_ff) begin
               fin = 1'b1;
            end else begin
               phase_in = PH_ITEMHDR;
               fc_in    = '0;
               ws_in    = '0;
            end
         end
         if (fin) begin
            if (dup_seen) begin
               res[n_res] = mk(KIND_ERROR, 7'(tag_ff), 8'd0, 1'b0, ERR_DUPLICATE);
               n_res = n_res + 2'd1;
               phase_in = PH_IDLE;
            end else begin
               res[n_res] = mk(KIND_TAG_END, 7'(tag_ff), 8'd0, 1'b0, 3'd0);
               n_res = n_res + 2'd1;
               if ((CW'(tag_ff) + CW'(1)) >= texp_ff) begin
                  res[n_res] = mk(KIND_DONE, 7'(tag_ff), 8'd0, 1'b0, 3'd0);
                  n_res = n_res + 2'd1;
                  phase_in = PH_IDLE;
               end else begin
                  tag_in   = tag_ff + TAGW'(1);
                  phase_in = PH_NAME;
                  fc_in    = '0;
                  name_ctl.load       = 1'b1;
                  name_ctl.load_count = 8'(tag_in);
               end
            end
         end
         if (req_tlast) begin
            if (phase_in != PH_IDLE) begin
               res[n_res] = mk(KIND_ERROR, 7'(tag_in), 8'd0, 1'b0, ERR_TRUNCATED);
               n_res = n_res + 2'd1;
            end
            phase_in = PH_MAGIC;
            fc_in    = '0;
            ws_in    = '0;
            texp_in  = '0;
            tag_in   = '0;
            mult_in  = '0;
            items_in = '0;
            iidx_in  = '0;
            left_in  = '0;
            pos_in   = '0;
            name_ctl.clear = 1'b1;
         end
         if (n_res != 2'd0) begin
            res[n_res - 2'd1].last = 1'b1;
         end
      end
   end

   assign push_n = accept ? n_res : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC;
         fc_ff    <= '0;
         ws_ff    <= '0;
         texp_ff  <= '0;
         tag_ff   <= '0;
         mult_ff  <= '0;
         items_ff <= '0;
         iidx_ff  <= '0;
         left_ff  <= '0;
         pos_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         fc_ff    <= fc_in;
         ws_ff    <= ws_in;
         texp_ff  <= texp_in;
         tag_ff   <= tag_in;
         mult_ff  <= mult_in;
         items_ff <= items_in;
         iidx_ff  <= iidx_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
      end
   end

   thsp_name_check #(
      .MAX_TAGS         (MAX_TAGS),
      .NAME_FIELD_BYTES (NAME_FIELD_BYTES)
   ) u_name_check (
      .clock    (clock),
      .reset    (reset),
      .name_req (name_req),
      .name_ctl (name_ctl),
      .dup_seen (dup_seen)
   );

   thsp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_data (res),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_data  (head),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {5'd0, head.err, head.vlast, head.payload, head.tag};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;
endmodule

[tb/tagged_header_stream_parser_test.sv]
`timescale 1ns / 1ps
module tagged_header_stream_parser_test;
   import thsp_pkg::*;

   localparam int NameBytes = 64;
   localparam int VrBytes   = 4;
   localparam int TagLimit  = 128;
   localparam int WatchLimit = 3000;

   localparam int FLAW_NONE      = 0;
   localparam int FLAW_MAGIC     = 1;
   localparam int FLAW_COUNT     = 2;
   localparam int FLAW_HSYNC     = 3;
   localparam int FLAW_NAME_LONG = 4;
   localparam int FLAW_VR_LONG   = 5;
   localparam int FLAW_ISYNC     = 6;
   localparam int FLAW_TRUNCATE  = 7;
   localparam int FLAW_MANY_TAGS = 8;

   typedef struct {
      logic [7:0] b;
      logic       last;
   } header_byte_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   tagged_header_stream_parser i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   // parser state mirror
   phase_type   ph;
   logic [31:0] fcount, wshift, mult, nitems, iidx, left;
   logic [7:0]  ntags, tidx;
   logic [1:0]  pos;
   bit          dup;
   logic [7:0]  names [0:TagLimit*NameBytes-1];
   bit          mask [0:TagLimit-1];
   result_type  step_results[$];
   result_type  expected_results[$];

   header_byte_type pending_bytes[$];
   header_byte_type bq[$];
   header_byte_type next_byte;
   int total_bytes = 0;
   int sent_bytes = 0;
   int errors = 0;
   int hold_left = 0;
   bit held = 0;
   int watch = 0;

   logic [7:0] pool_bytes [0:5][0:63];
   int         pool_len [0:5];

   function automatic void put(kind_type k, logic [7:0] p, bit vl, logic [2:0] e);
      result_type r;
      if (step_results.size() < ResultsPerItem) begin
         r.kind = k; r.tag = tidx[6:0]; r.payload = p; r.vlast = vl; r.err = e; r.last = 0;
         step_results.insert(step_results.size(), r);
      end
   endfunction

   function automatic void fail(err_type e);
      put(KIND_ERROR, '0, 0, e);
      ph = PH_IDLE;
   endfunction

   function automatic void open_name();
      ph = PH_NAME;
      fcount = 0;
      dup = 0;
      for (int j = 0; j < TagLimit; j++) mask[j] = (j < tidx);
   endfunction

   function automatic void clear_buffer();
      ph = PH_MAGIC; fcount = 0; wshift = 0; ntags = 0; tidx = 0; mult = 0;
      nitems = 0; iidx = 0; left = 0; pos = 0; dup = 0;
      for (int j = 0; j < TagLimit; j++) mask[j] = 0;
   endfunction

   function automatic void close_tag();
      if (dup) begin
         fail(ERR_DUPLICATE);
      end else begin
         put(KIND_TAG_END, '0, 0, '0);
         if (tidx + 1 >= ntags) begin
            put(KIND_DONE, '0, 0, '0);
            ph = PH_IDLE;
         end else begin
            tidx++;
            open_name();
         end
      end
   endfunction

   function automatic void advance_item();
      iidx++;
      if (iidx >= nitems) begin
         close_tag();
      end else begin
         ph = PH_ITEMHDR; fcount = 0; wshift = 0;
      end
   endfunction

   function automatic void close_value();
      if (pos != 0) ph = PH_ITEMPAD;
      else advance_item();
   endfunction

   function automatic bit kept();
      return mult == 0 || iidx < mult;
   endfunction

   function automatic void close_word(logic [31:0] w);
      case (ph)
         PH_MAGIC: if (w != MAGIC_WORD) fail(ERR_MAGIC); else ph = PH_SPARE;
         PH_SPARE: ph = PH_COUNT;
         PH_COUNT: begin
            if (w == 0 || w > TagLimit) fail(ERR_TAG_COUNT);
            else begin
               ntags = w[7:0];
               ph = PH_HSYNC;
            end
         end
         PH_HSYNC: if (w != SYNC_A) fail(ERR_HEADER_SYNC); else open_name();
         PH_VM: begin
            mult = w;
            ph = PH_VR;
         end
         PH_TYPE: ph = PH_NITEMS;
         PH_NITEMS: begin
            nitems = w;
            ph = PH_ISYNC;
         end
         default: begin
            if (w != SYNC_A && w != SYNC_B) fail(ERR_ITEM_SYNC);
            else begin
               iidx = 0;
               if (nitems == 0) close_tag();
               else begin
                  ph = PH_ITEMHDR; fcount = 0; wshift = 0;
               end
            end
         end
      endcase
   endfunction

   function automatic void take(logic [7:0] b);
      logic [31:0] w;
      logic [31:0] p;
      case (ph)
         PH_MAGIC, PH_SPARE, PH_COUNT, PH_HSYNC, PH_VM, PH_TYPE, PH_NITEMS, PH_ISYNC: begin
            wshift |= 32'(b) << (8 * fcount[1:0]);
            fcount++;
            if (fcount >= 4) begin
               w = wshift; wshift = 0; fcount = 0;
               close_word(w);
            end
         end
         PH_NAME: begin
            put(KIND_NAME, b, 0, '0);
            p = fcount;
            if (p >= NameBytes || tidx >= TagLimit) fail(ERR_NAME_LONG);
            else begin
               for (int j = 0; j < tidx; j++)
                  if (mask[j] && names[j*NameBytes+p] != b) mask[j] = 0;
               names[tidx*NameBytes+p] = b;
               fcount++;
               if (b == 0) begin
                  for (int j = 0; j < tidx; j++) if (mask[j]) dup = 1;
                  ph = PH_NAMEPAD;
               end else if (fcount >= NameBytes - 1) fail(ERR_NAME_LONG);
            end
         end
         PH_NAMEPAD: begin
            fcount++;
            if (fcount >= NameBytes) begin
               ph = PH_VM; fcount = 0; wshift = 0;
            end
         end
         PH_VR: begin
            put(KIND_VR, b, 0, '0);
            fcount++;
            if (b == 0) ph = PH_VRPAD;
            else if (fcount >= VrBytes - 1) fail(ERR_VR_LONG);
         end
         PH_VRPAD: begin
            fcount++;
            if (fcount >= VrBytes) begin
               ph = PH_TYPE; fcount = 0; wshift = 0;
            end
         end
         PH_ITEMHDR: begin
            if (fcount >= 4 && fcount < 8) wshift |= 32'(b) << (8 * (fcount - 4));
            fcount++;
            if (fcount >= 16) begin
               left = wshift; wshift = 0; fcount = 0;
               if (left == 0) begin
                  if (kept()) put(KIND_EMPTY, '0, 0, '0);
                  close_value();
               end else ph = PH_DATA;
            end
         end
         PH_DATA: begin
            if (kept()) put(KIND_VALUE, b, left == 1, '0);
            left--;
            if (left == 0) close_value();
         end
         PH_ITEMPAD: if (pos == 0) advance_item();
         default: ;
      endcase
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic last);
      step_results.delete();
      pos = pos + 2'd1;
      take(b);
      if (last) begin
         if (ph != PH_IDLE) fail(ERR_TRUNCATED);
         clear_buffer();
      end
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1;
      foreach (step_results[i]) expected_results.insert(expected_results.size(), step_results[i]);
   endfunction

   // stimulus building
   function automatic void add(int b);
      header_byte_type h;
      h.b = b[7:0]; h.last = 0;
      bq.insert(bq.size(), h);
   endfunction

   function automatic void add_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) add(int'(w[8*i +: 8]));
   endfunction

   function automatic void build_buffer(int flaw);
      int ntag, nlen, vlen, items, dlen, pick, cut, stop;
      bq.delete();
      stop = 0;
      if (flaw == FLAW_NONE || flaw == FLAW_TRUNCATE) ntag = $urandom_range(1, 2);
      else ntag = 1;
      add_word(flaw == FLAW_MAGIC ? (MAGIC_WORD ^ (32'd1 << $urandom_range(31))) : MAGIC_WORD);
      if (flaw == FLAW_MAGIC) stop = bq.size();
      add_word($urandom());
      if (flaw == FLAW_COUNT) begin
         add_word($urandom_range(1) ? 32'd0 : 129 + $urandom_range(1000));
         stop = bq.size();
      end else begin
         add_word(flaw == FLAW_MANY_TAGS ? TagLimit : ntag);
      end
      add_word(flaw == FLAW_HSYNC ? SYNC_B : SYNC_A);
      if (flaw == FLAW_HSYNC) stop = bq.size();
      // full tag count accepted, buffer ends inside the first name field
      if (flaw == FLAW_MANY_TAGS) stop = bq.size() + $urandom_range(1, 20);
      for (int t = 0; t < ntag; t++) begin
         if (flaw == FLAW_NAME_LONG && t == ntag - 1) begin
            for (int i = 0; i < 63; i++) add($urandom_range(1, 255));
            add($urandom());
            stop = bq.size();
         end else begin
            if ($urandom_range(11) == 0) begin
               nlen = 62;
               for (int i = 0; i < nlen; i++) add($urandom_range(1, 255));
            end else begin
               pick = $urandom_range(5);
               nlen = pool_len[pick];
               for (int i = 0; i < nlen; i++) add(int'(pool_bytes[pick][i]));
            end
            add(0);
            for (int i = nlen + 1; i < NameBytes; i++) add($urandom());
         end
         add_word($urandom_range(7) == 0 ? $urandom() : $urandom_range(3));
         if (flaw == FLAW_VR_LONG && t == ntag - 1) begin
            for (int i = 0; i < 3; i++) add($urandom_range(1, 255));
            add($urandom());
            stop = bq.size();
         end else begin
            vlen = $urandom_range(2);
            for (int i = 0; i < vlen; i++) add($urandom_range(1, 255));
            add(0);
            for (int i = vlen + 1; i < VrBytes; i++) add($urandom());
         end
         add_word($urandom());
         items = $urandom_range(3);
         add_word(items);
         if (flaw == FLAW_ISYNC && t == ntag - 1) begin
            add_word($urandom_range(1, 76));
            stop = bq.size();
         end else begin
            add_word($urandom_range(1) ? SYNC_A : SYNC_B);
         end
         for (int k = 0; k < items; k++) begin
            dlen = $urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(7);
            add_word($urandom());
            add_word(dlen);
            add_word($urandom());
            add_word($urandom());
            for (int i = 0; i < dlen; i++) add($urandom());
            while (bq.size() % 4 != 0) add($urandom());
         end
      end
      if (flaw == FLAW_TRUNCATE) begin
         cut = $urandom_range(1, bq.size() - 1);
         while (bq.size() > cut) void'(bq.pop_back());
      end else if (stop > 0) begin
         // bytes after the fault are ignored, keep only a few
         cut = stop + $urandom_range(3);
         while (bq.size() > cut) void'(bq.pop_back());
      end else begin
         if ($urandom_range(1)) repeat ($urandom_range(1, 3)) add($urandom());
      end
      bq[bq.size()-1].last = 1;
      foreach (bq[i]) pending_bytes.insert(pending_bytes.size(), bq[i]);
   endfunction

   function automatic void build_noise();
      header_byte_type h;
      int n;
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
         h.b = 8'($urandom()); h.last = (i == n - 1);
         pending_bytes.insert(pending_bytes.size(), h);
      end
   endfunction

   function automatic int sender_idle();
      int m;
      m = total_bytes == 0 ? 0 : sent_bytes * 3 / total_bytes;
      return m == 0 ? 25 : (m == 1 ? 53 : 0);
   endfunction

   function automatic int receiver_idle();
      int m;
      m = total_bytes == 0 ? 0 : sent_bytes * 3 / total_bytes;
      return m == 0 ? 53 : (m == 1 ? 25 : 0);
   endfunction

   initial begin
      int flaw;
      for (int i = 0; i < TagLimit * NameBytes; i++) names[i] = 0;
      clear_buffer();
      for (int p = 0; p < 6; p++) begin
         pool_len[p] = $urandom_range(6);
         for (int i = 0; i < 64; i++) pool_bytes[p][i] = 8'($urandom_range(1, 255));
      end
      // directed: clean, each error but duplicate, full tag count
      build_buffer(FLAW_NONE);
      build_buffer(FLAW_MAGIC);
      build_buffer(FLAW_COUNT);
      build_buffer(FLAW_HSYNC);
      build_buffer(FLAW_NAME_LONG);
      build_buffer(FLAW_VR_LONG);
      build_buffer(FLAW_ISYNC);
      build_buffer(FLAW_TRUNCATE);
      build_buffer(FLAW_MANY_TAGS);
      while (pending_bytes.size() < 500) begin
         flaw = $urandom_range(99);
         if (flaw < 65) build_buffer(FLAW_NONE);
         else if (flaw < 90) build_buffer($urandom_range(FLAW_MAGIC, FLAW_TRUNCATE));
         else build_noise();
      end
      total_bytes = pending_bytes.size();
      repeat (7) @(posedge clock);
      reset <= 0;
      while (pending_bytes.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= 0;
         req_tlast  <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tlast);
            sent_bytes++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle()) begin
               next_byte = pending_bytes.pop_front();
               req_tvalid <= 1;
               req_tdata  <= next_byte.b;
               req_tlast  <= next_byte.last;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser; got.tag = rsp_tdata[6:0]; got.payload = rsp_tdata[14:7];
            got.vlast = rsp_tdata[15]; got.err = rsp_tdata[18:16]; got.last = rsp_tlast;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
               end
            end
         end
         // long stall so the result queue fills and req backs up
         if (!held && sent_bytes >= total_bytes / 6) begin
            held = 1;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         watch <= 0;
      end else if (watch >= WatchLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         watch <= watch + 1;
      end
   end

endmodule
